/* hw/rtl/tcc_pkg.sv */
package tcc_pkg;

   // Longest arctangent table that the angle unit supports.
   localparam int TabLen = 24;

   // Angle accumulator: 2^-16 degree per count, wide enough for +/-180 degrees plus
   // the sum of all table entries.
   localparam int AngW = 26;
   typedef logic signed [AngW-1:0] angle_acc_type;

   localparam angle_acc_type Deg180 = 26'sd11796480;

   // Output limits in 1/64 degree.
   localparam int RollLim  = 5760;
   localparam int PitchLim = 11520;
   localparam int HeadLo   = -5760;
   localparam int HeadHi   = 17280;
   localparam int Deg90    = 5760;

   // One sensor sample as it travels down the pipeline.
   typedef struct packed {
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic signed [15:0] mx;
      logic signed [15:0] my;
      logic signed [15:0] mz;
   } sample_type;

   // Special cases that override the computed angles at the end.
   typedef struct packed {
      logic nz;   // acceleration is all zero
      logic qz;   // acceleration is along x only
      logic axp;  // ax is positive
   } flags_type;

   // Rounded arctangent of 2^-idx in 2^-16 degree.
   function automatic angle_acc_type atan_entry(input int unsigned idx);
      angle_acc_type v;
      case (idx)
         0:       v = 26'sd2949120;
         1:       v = 26'sd1740967;
         2:       v = 26'sd919879;
         3:       v = 26'sd466945;
         4:       v = 26'sd234379;
         5:       v = 26'sd117304;
         6:       v = 26'sd58666;
         7:       v = 26'sd29335;
         8:       v = 26'sd14668;
         9:       v = 26'sd7334;
         10:      v = 26'sd3667;
         11:      v = 26'sd1833;
         12:      v = 26'sd917;
         13:      v = 26'sd458;
         14:      v = 26'sd229;
         15:      v = 26'sd115;
         16:      v = 26'sd57;
         17:      v = 26'sd29;
         18:      v = 26'sd14;
         19:      v = 26'sd7;
         20:      v = 26'sd4;
         21:      v = 26'sd2;
         22:      v = 26'sd1;
         default: v = 26'sd0;
      endcase
      return v;
   endfunction

endpackage

/* hw/rtl/tcc_cordic.sv */
// Pipelined vectoring rotator: one iteration per register stage; the angle of (x, y)
// comes out of the last stage.
module tcc_cordic #(
   parameter int W     = 24,
   parameter int STEPS = 16
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [W-1:0]    x_in,
   input  logic signed [W-1:0]    y_in,
   output tcc_pkg::angle_acc_type z_out
);

   logic signed [W-1:0]    x_ff [0:STEPS];
   logic signed [W-1:0]    y_ff [0:STEPS];
   tcc_pkg::angle_acc_type z_ff [0:STEPS];

   // Fold the left half plane over to the right and start at +/-180 degrees.
   always_ff @(posedge clock) begin
      if (en) begin
         if (x_in < 0) begin
            x_ff[0] <= -x_in;
            y_ff[0] <= -y_in;
            z_ff[0] <= (y_in >= 0) ? tcc_pkg::Deg180 : -tcc_pkg::Deg180;
         end else begin
            x_ff[0] <= x_in;
            y_ff[0] <= y_in;
            z_ff[0] <= '0;
         end
      end
   end

   // Each stage rotates toward y = 0 by the table angle of its own index.
   for (genvar i = 0; i < STEPS; i++) begin : g_iter
      always_ff @(posedge clock) begin
         if (en) begin
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + tcc_pkg::atan_entry(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - tcc_pkg::atan_entry(i);
            end
         end
      end
   end

   assign z_out = z_ff[STEPS];

endmodule

/* hw/rtl/tilt_compensated_compass.sv */
// Tilt-compensated compass. One transfer on the req_ channel carries one
// accelerometer and one magnetometer sample (three signed axes each); one
// transfer on the rsp_ channel returns roll, pitch and heading in 1/64 degree
// and a flag for a zero acceleration vector, in the same order as the requests.
// The block keeps no state between samples.
// Throughput is one sample per cycle while rsp_stall does not hold the pipeline. The
// pipeline has two stages for the squares and sums, twenty for the two square roots
// (one root bit per stage), four for the rotation products, CORDIC_STEPS + 1 (with
// CORDIC_STEPS capped at the table length) for the three angle units running side
// by side, and one for rounding and limiting.
// The whole pipeline advances together. When rsp_stall holds back a valid
// response, every stage holds and req_stall is raised in the same cycle; no
// sample is lost or repeated.
// Synchronous reset clears all valid bits; the pipeline then accepts a request
// in the first cycle after reset.
module tilt_compensated_compass #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_mag_x,
   input  logic signed [15:0] req_mag_y,
   input  logic signed [15:0] req_mag_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [13:0] rsp_roll_angle,
   output logic signed [14:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_heading_angle,
   output logic               rsp_zero_norm
);

   localparam int Steps = (CORDIC_STEPS > tcc_pkg::TabLen) ? tcc_pkg::TabLen : CORDIC_STEPS;
   localparam int SqBits = 20;
   localparam int RemW   = 42;
   localparam int Lat    = Steps + 28;
   localparam int RpW    = 24;
   localparam int HdW    = 60;

   logic en;
   logic [Lat-1:0] vld_ff;

   // Global advance: everything moves unless a waiting response is stalled.
   assign en        = !vld_ff[Lat-1] || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = vld_ff[Lat-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[Lat-2:0], req_valid};
      end
   end

   // Stage 1: squares of the acceleration axes.
   tcc_pkg::sample_type s1_ff;
   logic [31:0] ax2_ff, ay2_ff, az2_ff;
   logic signed [31:0] ax2_in, ay2_in, az2_in;

   assign ax2_in = req_accel_x * req_accel_x;
   assign ay2_in = req_accel_y * req_accel_y;
   assign az2_in = req_accel_z * req_accel_z;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff  <= '{req_accel_x, req_accel_y, req_accel_z, req_mag_x, req_mag_y, req_mag_z};
         ax2_ff <= $unsigned(ax2_in);
         ay2_ff <= $unsigned(ay2_in);
         az2_ff <= $unsigned(az2_in);
      end
   end

   // Stage 2: squared norms and the special-case flags.
   logic [31:0] qq_in, nn_in;

   tcc_pkg::sample_type sq_s_ff  [0:SqBits];
   tcc_pkg::flags_type  sq_f_ff  [0:SqBits];
   logic [RemW-1:0]     q_rem_ff [0:SqBits];
   logic [RemW-1:0]     n_rem_ff [0:SqBits];
   logic [SqBits-1:0]   q_rt_ff  [0:SqBits];
   logic [SqBits-1:0]   n_rt_ff  [0:SqBits];

   assign qq_in = ay2_ff + az2_ff;
   assign nn_in = qq_in + ax2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_s_ff[0]  <= s1_ff;
         sq_f_ff[0]  <= '{nz: (nn_in == '0), qz: (qq_in == '0),
                          axp: (!s1_ff.ax[15] && (s1_ff.ax != '0))};
         q_rem_ff[0] <= {2'b00, qq_in, 8'h00};
         n_rem_ff[0] <= {2'b00, nn_in, 8'h00};
         q_rt_ff[0]  <= '0;
         n_rt_ff[0]  <= '0;
      end
   end

   // Square roots, one result bit per stage from the top bit down.
   for (genvar j = 0; j < SqBits; j++) begin : g_sqrt
      localparam int K = SqBits - 1 - j;
      logic [RemW-1:0] q_t, n_t;

      assign q_t = ({{(RemW-SqBits){1'b0}}, q_rt_ff[j]} << (K + 1)) | (RemW'(1) << (2 * K));
      assign n_t = ({{(RemW-SqBits){1'b0}}, n_rt_ff[j]} << (K + 1)) | (RemW'(1) << (2 * K));

      always_ff @(posedge clock) begin
         if (en) begin
            sq_s_ff[j+1] <= sq_s_ff[j];
            sq_f_ff[j+1] <= sq_f_ff[j];
            if (q_rem_ff[j] >= q_t) begin
               q_rem_ff[j+1] <= q_rem_ff[j] - q_t;
               q_rt_ff[j+1]  <= q_rt_ff[j] | (SqBits'(1) << K);
            end else begin
               q_rem_ff[j+1] <= q_rem_ff[j];
               q_rt_ff[j+1]  <= q_rt_ff[j];
            end
            if (n_rem_ff[j] >= n_t) begin
               n_rem_ff[j+1] <= n_rem_ff[j] - n_t;
               n_rt_ff[j+1]  <= n_rt_ff[j] | (SqBits'(1) << K);
            end else begin
               n_rem_ff[j+1] <= n_rem_ff[j];
               n_rt_ff[j+1]  <= n_rt_ff[j];
            end
         end
      end
   end

   // Product stage 1: first products of the rotation.
   tcc_pkg::sample_type p1_s_ff;
   tcc_pkg::flags_type  p1_f_ff;
   logic signed [20:0]  p1_q_ff;
   logic signed [36:0]  t1_ff, u_ff;
   logic signed [31:0]  t2_ff, w_ff;
   logic signed [37:0]  a_ff;
   logic signed [20:0]  qs_in, ns_in;
   logic signed [16:0]  naz_in;

   assign qs_in  = $signed({1'b0, q_rt_ff[SqBits]});
   assign ns_in  = $signed({1'b0, n_rt_ff[SqBits]});
   assign naz_in = -17'(sq_s_ff[SqBits].az);

   always_ff @(posedge clock) begin
      if (en) begin
         p1_s_ff <= sq_s_ff[SqBits];
         p1_f_ff <= sq_f_ff[SqBits];
         p1_q_ff <= qs_in;
         t1_ff   <= qs_in * sq_s_ff[SqBits].my;
         u_ff    <= qs_in * sq_s_ff[SqBits].mz;
         t2_ff   <= sq_s_ff[SqBits].ax * sq_s_ff[SqBits].mz;
         w_ff    <= sq_s_ff[SqBits].ax * sq_s_ff[SqBits].my;
         a_ff    <= naz_in * ns_in;
      end
   end

   // Product stage 2: bracketed sums and the vertical term of x.
   tcc_pkg::sample_type p2_s_ff;
   tcc_pkg::flags_type  p2_f_ff;
   logic signed [20:0]  p2_q_ff;
   logic signed [37:0]  s1w_ff, s2w_ff;
   logic signed [53:0]  b_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p2_s_ff <= p1_s_ff;
         p2_f_ff <= p1_f_ff;
         p2_q_ff <= p1_q_ff;
         s1w_ff  <= 38'(t1_ff) + (38'(t2_ff) <<< 4);
         s2w_ff  <= 38'(u_ff) - (38'(w_ff) <<< 4);
         b_ff    <= a_ff * p1_s_ff.mx;
      end
   end

   // Product stage 3: rotated y and the horizontal term of x.
   tcc_pkg::sample_type p3_s_ff;
   tcc_pkg::flags_type  p3_f_ff;
   logic signed [20:0]  p3_q_ff;
   logic signed [58:0]  hy_ff;
   logic signed [53:0]  hx2_ff;
   logic signed [53:0]  p3_b_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p3_s_ff <= p2_s_ff;
         p3_f_ff <= p2_f_ff;
         p3_q_ff <= p2_q_ff;
         hy_ff   <= p2_q_ff * s1w_ff;
         hx2_ff  <= p2_s_ff.ay * s2w_ff;
         p3_b_ff <= b_ff;
      end
   end

   // Product stage 4: angle unit inputs, with the vertical case substituted.
   logic signed [HdW-1:0] hx_in, hy_in;
   logic signed [HdW-1:0] hd_x_ff, hd_y_ff;
   logic signed [RpW-1:0] rl_x_ff, rl_y_ff, pt_x_ff, pt_y_ff;
   tcc_pkg::flags_type    p4_f_ff;

   always_comb begin
      if (p3_f_ff.qz) begin
         hx_in = -HdW'(p3_s_ff.mx);
         hy_in = p3_f_ff.axp ? HdW'(p3_s_ff.mz) : -HdW'(p3_s_ff.mz);
      end else begin
         hx_in = (HdW'(p3_b_ff) <<< 4) + (HdW'(hx2_ff) <<< 4);
         hy_in = HdW'(hy_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p4_f_ff <= p3_f_ff;
         hd_x_ff <= hx_in;
         hd_y_ff <= hy_in;
         rl_x_ff <= RpW'(p3_q_ff);
         rl_y_ff <= RpW'(p3_s_ff.ax) <<< 4;
         pt_x_ff <= -RpW'(p3_s_ff.az);
         pt_y_ff <= RpW'(p3_s_ff.ay);
      end
   end

   // Three angle units side by side; flags ride alongside.
   tcc_pkg::angle_acc_type zr, zp, zh;
   tcc_pkg::flags_type     fl_ff [0:Steps];

   tcc_cordic #(.W(RpW), .STEPS(Steps)) u_roll (
      .clock(clock), .en(en), .x_in(rl_x_ff), .y_in(rl_y_ff), .z_out(zr)
   );

   tcc_cordic #(.W(RpW), .STEPS(Steps)) u_pitch (
      .clock(clock), .en(en), .x_in(pt_x_ff), .y_in(pt_y_ff), .z_out(zp)
   );

   tcc_cordic #(.W(HdW), .STEPS(Steps)) u_head (
      .clock(clock), .en(en), .x_in(hd_x_ff), .y_in(hd_y_ff), .z_out(zh)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         fl_ff[0] <= p4_f_ff;
      end
   end

   for (genvar k = 0; k < Steps; k++) begin : g_flags
      always_ff @(posedge clock) begin
         if (en) begin
            fl_ff[k+1] <= fl_ff[k];
         end
      end
   end

   // Output stage: round to 1/64 degree, apply special cases and limits.
   tcc_pkg::angle_acc_type zr_rnd, zp_rnd, zh_rnd;
   logic signed [17:0] roll_in, pitch_in, head_in;
   logic signed [13:0] roll_ff;
   logic signed [14:0] pitch_ff;
   logic signed [15:0] head_ff;
   logic               zn_ff;
   tcc_pkg::flags_type fo;

   function automatic logic signed [17:0] lim(input logic signed [17:0] v,
                                              input logic signed [17:0] lo,
                                              input logic signed [17:0] hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   assign fo     = fl_ff[Steps];
   assign zr_rnd = (zr + 26'sd512) >>> 10;
   assign zp_rnd = (zp + 26'sd512) >>> 10;
   assign zh_rnd = (zh + 26'sd512) >>> 10;

   always_comb begin
      roll_in  = -18'(zr_rnd);
      pitch_in = 18'(zp_rnd);
      head_in  = 18'(zh_rnd) + 18'(tcc_pkg::Deg90);
      if (fo.qz) begin
         roll_in  = fo.axp ? -18'(tcc_pkg::RollLim) : 18'(tcc_pkg::RollLim);
         pitch_in = 18'(tcc_pkg::PitchLim);
      end
      roll_in  = lim(roll_in, -18'(tcc_pkg::RollLim), 18'(tcc_pkg::RollLim));
      pitch_in = lim(pitch_in, -18'(tcc_pkg::PitchLim), 18'(tcc_pkg::PitchLim));
      head_in  = lim(head_in, 18'(tcc_pkg::HeadLo), 18'(tcc_pkg::HeadHi));
      if (fo.nz) begin
         roll_in  = '0;
         pitch_in = '0;
         head_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         roll_ff  <= roll_in[13:0];
         pitch_ff <= pitch_in[14:0];
         head_ff  <= head_in[15:0];
         zn_ff    <= fo.nz;
      end
   end

   assign rsp_roll_angle    = roll_ff;
   assign rsp_pitch_angle   = pitch_ff;
   assign rsp_heading_angle = head_ff;
   assign rsp_zero_norm     = zn_ff;

endmodule
